// ===== src/fpr_pkg.sv =====
package fpr_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SECOND = 2'd1;

    // header reset values
    localparam logic [7:0] HEADER_FIRST_RESET  = 8'd170;
    localparam logic [7:0] HEADER_SECOND_RESET = 8'd85;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

    // finished frame handed from the parser to the emitter
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  command;
        logic [7:0]  frame_length;
        logic [15:0] error_count;
    } frame_job_t;

endpackage

// ===== src/framed_packet_receiver.sv =====
// Framed packet receiver: takes one received byte per request, hunts for the
// two configurable header bytes, then parses command, length, payload and an
// 8-bit sum checksum. Payload bytes are written into an internal one-port-read,
// one-port-write RAM as they arrive. Bytes are taken only while no results
// are pending. A bad length or bad checksum gives one error result
// (status 2 or 1) with the wrapped 16-bit error count; a good frame replays its
// payload from the RAM, one result per byte (or one empty result for length
// zero), with last set on the final one. While results are pending the byte
// input is stalled: each payload result passes through a RAM read, then the
// output register, plus any wait on out_ready, so a good frame holds the input
// from its checksum byte until its final result leaves. Configuration writes
// are always ready and should be issued only while no frame is in progress.
module framed_packet_receiver
    import fpr_pkg::*;
#(
    parameter int PAYLOAD_MAX = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    // received bytes
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,
    // results
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic [7:0]             command,
    output logic [7:0]             frame_length,
    output logic [4:0]             byte_index,
    output logic [7:0]             payload_byte,
    output logic                   has_byte,
    output logic                   last,
    output logic [15:0]            error_count
);

    localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int CW = $clog2(PAYLOAD_MAX + 1);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          job_valid;
    logic          job_ready;
    frame_job_t    job;

    assign cfg_ready = 1'b1;

    // header hunt, length and checksum
    fpr_parse #(
        .PAYLOAD_MAX (PAYLOAD_MAX),
        .AW          (AW),
        .CW          (CW)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready)
    );

    // payload RAM
    fpr_store #(
        .DEPTH (PAYLOAD_MAX),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result replay
    fpr_emit #(
        .AW (AW),
        .CW (CW)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (job),
        .job_ready    (job_ready),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .command      (command),
        .frame_length (frame_length),
        .byte_index   (byte_index),
        .payload_byte (payload_byte),
        .has_byte     (has_byte),
        .last         (last),
        .error_count  (error_count)
    );

endmodule

// ===== src/fpr_store.sv =====
module fpr_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/fpr_parse.sv =====
module fpr_parse
    import fpr_pkg::*;
#(
    parameter int PAYLOAD_MAX = 32,
    parameter int AW          = 5,
    parameter int CW          = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration writes
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    // received bytes
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,
    // payload store write port
    output logic                   wr_en,
    output logic [AW-1:0]          wr_addr,
    output logic [7:0]             wr_data,
    // finished frames
    output logic                   job_valid,
    output frame_job_t             job,
    input  logic                   job_ready
);

    typedef enum logic [2:0] {
        P_HUNT1,
        P_HUNT2,
        P_CMD,
        P_LEN,
        P_DATA,
        P_SUM
    } phase_t;

    phase_t        phase_reg;
    logic [7:0]    hdr1_reg;
    logic [7:0]    hdr2_reg;
    logic [7:0]    cmd_reg;
    logic [7:0]    len_reg;
    logic [CW-1:0] fill_reg;
    logic [7:0]    sum_reg;
    logic [15:0]   err_cnt_reg;

    logic          in_accept;
    logic          len_bad;
    logic          sum_good;
    logic [CW-1:0] fill_inc;
    logic [15:0]   err_cnt_inc;

    // input is held off while the emitter replays a frame or holds a result
    assign in_ready    = job_ready;
    assign in_accept   = in_valid && in_ready;
    assign len_bad     = rx_byte > 8'(PAYLOAD_MAX);
    assign sum_good    = rx_byte == sum_reg;
    assign fill_inc    = fill_reg + 1'b1;
    assign err_cnt_inc = err_cnt_reg + 16'd1;

    // payload bytes go straight to the store
    assign wr_en   = in_accept && (phase_reg == P_DATA);
    assign wr_addr = fill_reg[AW-1:0];
    assign wr_data = rx_byte;

    // frame end: bad length or checksum byte
    always_comb
    begin
        job_valid        = 1'b0;
        job.status       = STATUS_OK;
        job.command      = cmd_reg;
        job.frame_length = len_reg;
        job.error_count  = err_cnt_reg;
        case (phase_reg)
            P_LEN:
            begin
                job_valid        = in_valid && len_bad;
                job.status       = STATUS_BAD_LEN;
                job.frame_length = rx_byte;
                job.error_count  = err_cnt_inc;
            end
            P_SUM:
            begin
                job_valid = in_valid;
                if (!sum_good)
                begin
                    job.status      = STATUS_BAD_SUM;
                    job.error_count = err_cnt_inc;
                end
            end
            default:
            begin
                job_valid = 1'b0;
            end
        endcase
    end

    // header registers and frame parser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= P_HUNT1;
            hdr1_reg    <= HEADER_FIRST_RESET;
            hdr2_reg    <= HEADER_SECOND_RESET;
            cmd_reg     <= '0;
            len_reg     <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            err_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_HEADER_FIRST:  hdr1_reg <= cfg_data;
                    REG_HEADER_SECOND: hdr2_reg <= cfg_data;
                    default:           ;
                endcase
            end
            if (in_accept)
            begin
                case (phase_reg)
                    P_HUNT1:
                    begin
                        if (rx_byte == hdr1_reg)
                        begin
                            phase_reg <= P_HUNT2;
                        end
                    end
                    P_HUNT2:
                    begin
                        // second header byte wins, a repeated first byte keeps waiting
                        if (rx_byte == hdr2_reg)
                        begin
                            phase_reg <= P_CMD;
                        end
                        else if (rx_byte != hdr1_reg)
                        begin
                            phase_reg <= P_HUNT1;
                        end
                    end
                    P_CMD:
                    begin
                        cmd_reg   <= rx_byte;
                        phase_reg <= P_LEN;
                    end
                    P_LEN:
                    begin
                        len_reg  <= rx_byte;
                        sum_reg  <= cmd_reg + rx_byte;
                        fill_reg <= '0;
                        if (len_bad)
                        begin
                            err_cnt_reg <= err_cnt_inc;
                            phase_reg   <= P_HUNT1;
                        end
                        else if (rx_byte == 8'd0)
                        begin
                            phase_reg <= P_SUM;
                        end
                        else
                        begin
                            phase_reg <= P_DATA;
                        end
                    end
                    P_DATA:
                    begin
                        fill_reg <= fill_inc;
                        sum_reg  <= sum_reg + rx_byte;
                        if (8'(fill_inc) >= len_reg)
                        begin
                            phase_reg <= P_SUM;
                        end
                    end
                    P_SUM:
                    begin
                        if (!sum_good)
                        begin
                            err_cnt_reg <= err_cnt_inc;
                        end
                        phase_reg <= P_HUNT1;
                    end
                    default:
                    begin
                        phase_reg <= P_HUNT1;
                    end
                endcase
            end
        end
    end

endmodule

// ===== src/fpr_emit.sv =====
module fpr_emit
    import fpr_pkg::*;
#(
    parameter int AW = 5,
    parameter int CW = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    // finished frames
    input  logic          job_valid,
    input  frame_job_t    job,
    output logic          job_ready,
    // payload store read port
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  logic [7:0]    rd_data,
    // results
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    status,
    output logic [7:0]    command,
    output logic [7:0]    frame_length,
    output logic [4:0]    byte_index,
    output logic [7:0]    payload_byte,
    output logic          has_byte,
    output logic          last,
    output logic [15:0]   error_count
);

    typedef enum logic [1:0] {
        E_IDLE,
        E_FETCH,
        E_HOLD
    } emit_state_t;

    emit_state_t   state_reg;
    frame_job_t    job_reg;
    logic [CW-1:0] idx_reg;
    logic          out_valid_reg;
    logic [4:0]    byte_index_reg;
    logic [7:0]    payload_reg;
    logic          has_byte_reg;
    logic          last_reg;

    logic          job_take;
    logic          job_replay;
    logic [CW-1:0] idx_inc;
    logic          out_take;

    assign job_ready  = state_reg == E_IDLE;
    assign job_take   = job_valid && job_ready;
    assign job_replay = (job.status == STATUS_OK) && (job.frame_length != 8'd0);
    assign idx_inc    = idx_reg + 1'b1;
    assign out_take   = out_valid_reg && out_ready;

    // read entry 0 when a frame with payload starts, the next entry when a non-final result leaves
    assign rd_en   = (job_take && job_replay) || ((state_reg == E_HOLD) && out_take && !last_reg);
    assign rd_addr = (state_reg == E_IDLE) ? '0 : idx_inc[AW-1:0];

    assign out_valid    = out_valid_reg;
    assign status       = job_reg.status;
    assign command      = job_reg.command;
    assign frame_length = job_reg.frame_length;
    assign error_count  = job_reg.error_count;
    assign byte_index   = byte_index_reg;
    assign payload_byte = payload_reg;
    assign has_byte     = has_byte_reg;
    assign last         = last_reg;

    // replay sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= E_IDLE;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            job_reg        <= '0;
            byte_index_reg <= '0;
            payload_reg    <= '0;
            has_byte_reg   <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            case (state_reg)
                E_IDLE:
                begin
                    if (job_take)
                    begin
                        job_reg <= job;
                        idx_reg <= '0;
                        if (job_replay)
                        begin
                            state_reg <= E_FETCH;
                        end
                        else
                        begin
                            // error or empty frame: one result without data
                            byte_index_reg <= '0;
                            payload_reg    <= '0;
                            has_byte_reg   <= 1'b0;
                            last_reg       <= 1'b1;
                            out_valid_reg  <= 1'b1;
                            state_reg      <= E_HOLD;
                        end
                    end
                end
                E_FETCH:
                begin
                    byte_index_reg <= 5'(idx_reg);
                    payload_reg    <= rd_data;
                    has_byte_reg   <= 1'b1;
                    last_reg       <= 8'(idx_inc) == job_reg.frame_length;
                    out_valid_reg  <= 1'b1;
                    state_reg      <= E_HOLD;
                end
                E_HOLD:
                begin
                    if (out_take)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_reg)
                        begin
                            state_reg <= E_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_inc;
                            state_reg <= E_FETCH;
                        end
                    end
                end
                default:
                begin
                    state_reg     <= E_IDLE;
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    // a new frame only arrives with the output register empty
    a_job_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> !out_valid_reg)
        else $error("frame taken while a result is pending");

    // a data result always belongs to a good frame
    a_data_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && has_byte_reg) |-> (job_reg.status == STATUS_OK))
        else $error("payload result with error status");

    // a result without data is the only one of its frame
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !has_byte_reg) |-> last_reg)
        else $error("result without data not marked last");

    // a taken non-final result is followed by a store read, not a second result
    a_read_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && !last_reg) |=> (!out_valid_reg && (state_reg == E_FETCH)))
        else $error("replay skipped the store read");

endmodule
